// ===== src/lcgrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgrd_pkg
// Shared types and constants of the ranged random draw unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgrd_pkg;

  // Generator word and multiply-add constants
  localparam int unsigned STATE_W = 32;
  localparam logic [STATE_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [STATE_W-1:0] LCG_ADD = 32'd1013904223;

  // Raw value taken from the advanced state: bits RAW_SHIFT+RAW_W-1 .. RAW_SHIFT
  localparam int unsigned RAW_SHIFT = 8;
  localparam int unsigned RAW_W     = 15;

  // Span |a-b|+1 needs one bit more than the bounds
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SPAN_W = VAL_W + 1;

  // Step counter of the remainder unit
  localparam int unsigned CNT_W = $clog2(RAW_W + 1);

  // Command codes
  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_MOD,
    S_FIN
  } fsm_t;

endpackage : lcgrd_pkg

`default_nettype wire

// ===== src/lcgrd_if.sv =====
// ----------------------------------------------------------------------------
// lcgrd_req_if / lcgrd_rsp_if
// Valid/ready channels of the ranged random draw unit.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: seed or draw command
interface lcgrd_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] seed_value;
  logic signed [31:0] bound_a;
  logic signed [31:0] bound_b;

  modport source (output valid, output cmd, output seed_value, output bound_a,
                  output bound_b, input ready);
  modport sink   (input valid, input cmd, input seed_value, input bound_a,
                  input bound_b, output ready);
endinterface : lcgrd_req_if

// Response channel: drawn number
interface lcgrd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drawn_value;

  modport source (output valid, output drawn_value, input ready);
  modport sink   (input valid, input drawn_value, output ready);
endinterface : lcgrd_rsp_if

`default_nettype wire

// ===== src/lcgrd_mod_unit.sv =====
// ----------------------------------------------------------------------------
// lcgrd_mod_unit
// Restoring remainder unit: one dividend bit per cycle, one shared
// compare/subtract against the span.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgrd_mod_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [lcgrd_pkg::RAW_W-1:0]  dividend,
  input  wire logic [lcgrd_pkg::SPAN_W-1:0] divisor,
  output logic                              done,
  output logic [lcgrd_pkg::RAW_W-1:0]       remainder
);
  import lcgrd_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic [RAW_W-1:0]  dvd;
  logic [SPAN_W-1:0] div;
  logic [RAW_W-1:0]  rem;

  logic [RAW_W:0]    trial;
  logic              ge;
  logic [RAW_W:0]    diff;
  logic [RAW_W-1:0]  rem_next;

  // One restoring step: shift in next bit, subtract span if it fits
  always_comb begin
    trial    = {rem, dvd[RAW_W-1]};
    ge       = {{(SPAN_W-RAW_W-1){1'b0}}, trial} >= div;
    diff     = trial - div[RAW_W:0];
    rem_next = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(RAW_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[RAW_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // Last step happens at the edge where done is high
  assign done      = (cnt == CNT_W'(1));
  assign remainder = rem;

endmodule : lcgrd_mod_unit

`default_nettype wire

// ===== src/lcg_ranged_random_draw_unit.sv =====
// ----------------------------------------------------------------------------
// lcg_ranged_random_draw_unit
// 32-bit linear congruential generator with ranged draws:
// result = min(a,b) + state[22:8] mod (|a-b|+1).
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transaction
//  req     | in  | cmd, seed_value, bound_a, bound_b        | seed or draw
//  rsp     | out | drawn_value                              | one per draw
//
//  Seed: accepted in S_IDLE, no response; req.ready stays high.
//  Draw, distinct bounds: accept, multiply, add, 15 remainder steps in the
//  shared subtractor, then output load into the result register.
//  Draw, equal bounds: accept, multiply, output load; state not advanced.
//  A new request is accepted only once the sequencer is back in S_IDLE.
//  A pending response does not block accepting the next request; only the
//  final load waits for rsp.ready, which stretches the output cycle.
//  Reset clears state word to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_ranged_random_draw_unit (
  input  wire logic clk,
  input  wire logic rst,
  lcgrd_req_if.sink   req,
  lcgrd_rsp_if.source rsp
);
  import lcgrd_pkg::*;

  fsm_t state, state_next;

  logic [STATE_W-1:0] lcg_state;
  logic [STATE_W-1:0] prod;
  logic [STATE_W-1:0] lcg_sum;

  logic signed [VAL_W-1:0] a_reg, b_reg, lo;
  logic [SPAN_W-1:0]       span;
  logic                    eq;

  logic signed [SPAN_W-1:0] diff_ba;
  logic [SPAN_W-1:0]        mag;

  logic                    mod_start, mod_done;
  logic [RAW_W-1:0]        rem;

  logic                    out_vld;
  logic signed [VAL_W-1:0] drawn;
  logic signed [VAL_W-1:0] res;
  logic                    fin_load;

  logic acc, acc_seed;

  assign acc      = req.valid && req.ready;
  assign acc_seed = acc && (cmd_t'(req.cmd) == CMD_SEED);

  // Bound difference, exact in 33 bits
  always_comb begin
    diff_ba = {b_reg[VAL_W-1], b_reg} - {a_reg[VAL_W-1], a_reg};
    mag     = diff_ba[SPAN_W-1] ? SPAN_W'(-diff_ba) : diff_ba;
  end

  assign lcg_sum   = prod + LCG_ADD;
  assign mod_start = (state == S_ADD);
  assign res       = eq ? a_reg : VAL_W'(lo + {{(VAL_W-RAW_W){1'b0}}, rem});
  assign fin_load  = (state == S_FIN) && (!out_vld || rsp.ready);

  // Shared remainder unit
  lcgrd_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (lcg_sum[RAW_SHIFT +: RAW_W]),
    .divisor   (span),
    .done      (mod_done),
    .remainder (rem)
  );

  // Sequencer: next state and handshake
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && cmd_t'(req.cmd) == CMD_DRAW) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = (a_reg == b_reg) ? S_FIN : S_ADD;
      end
      S_ADD: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        if (mod_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (fin_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lcg_state <= '0;
      out_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_seed) begin
        lcg_state <= req.seed_value;
      end else if (state == S_ADD) begin
        lcg_state <= lcg_sum;
      end
      if (fin_load) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      a_reg <= req.bound_a;
      b_reg <= req.bound_b;
    end
    if (state == S_MUL) begin
      prod <= STATE_W'(lcg_state * LCG_MUL);
      eq   <= (a_reg == b_reg);
      lo   <= diff_ba[SPAN_W-1] ? b_reg : a_reg;
      span <= mag + 1'b1;
    end
    if (fin_load) drawn <= res;
  end

  assign rsp.valid       = out_vld;
  assign rsp.drawn_value = drawn;

  // Seed lands in the state word on the next cycle
  a_seed_load: assert property (@(posedge clk) disable iff (rst)
    acc_seed |=> lcg_state == $past(req.seed_value))
    else $error("seed not loaded into state");

  // Remainder is always below the span when a distinct-bound draw finishes
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !eq |-> {{(SPAN_W-RAW_W){1'b0}}, rem} < span)
    else $error("remainder not below span");

  // Remainder unit finishes only while the sequencer waits for it
  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder unit done outside modulo phase");

  // Equal-bound draw does not advance the state
  a_eq_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) && (a_reg == b_reg) |=> $stable(lcg_state))
    else $error("state advanced on equal bounds");

endmodule : lcg_ranged_random_draw_unit

`default_nettype wire
